// ===== src/conv2d_padded_strided_defines.svh =====
// Assertion macros for the 2D convolution block.
// No dependencies; included by the top level only.
`ifndef CONV2D_PADDED_STRIDED_DEFINES_SVH
`define CONV2D_PADDED_STRIDED_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Implication checked in the same cycle.
`define C2D_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("conv2d assertion failed");
// Implication checked in the next cycle.
`define C2D_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("conv2d assertion failed");
`else
`define C2D_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define C2D_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== src/c2d_pkg.sv =====
// Shared types and constants of the 2D convolution block.
// No dependencies; imported by c2d_ram and conv2d_padded_strided.
package c2d_pkg;

  // Default store depths.
  localparam int ACT_DEPTH_DEF        = 16384;
  localparam int WEIGHT_DEPTH_DEF     = 4096;
  localparam int MAX_OUT_CHANNELS_DEF = 64;

  // Store word widths.
  localparam int ACT_W  = 16;
  localparam int WGT_W  = 16;
  localparam int BIAS_W = 32;

  // Store index width, wide enough for any computed index.
  localparam int IDX_W = 24;
  typedef logic [IDX_W-1:0] idx_t;

  // Shared multiplier and accumulator widths.
  localparam int MUL_A_W = 25;
  localparam int MUL_B_W = 18;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = 48;

  localparam logic signed [ACC_W-1:0] SUM_MAX = 48'sh0000_7FFF_FFFF;
  localparam logic signed [ACC_W-1:0] SUM_MIN = -48'sh0000_8000_0000;

  // Item operations carried in tuser.
  typedef enum logic [1:0] {
    OP_LOAD_ACT  = 2'd0,
    OP_LOAD_WGT  = 2'd1,
    OP_LOAD_BIAS = 2'd2,
    OP_COMPUTE   = 2'd3
  } op_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_CHANNELS_IN   = 3'd0,
    CFG_HEIGHT_IN     = 3'd1,
    CFG_WIDTH_IN      = 3'd2,
    CFG_CHANNELS_OUT  = 3'd3,
    CFG_KERNEL_HEIGHT = 3'd4,
    CFG_KERNEL_WIDTH  = 3'd5,
    CFG_STRIDE        = 3'd6,
    CFG_PADDING       = 3'd7
  } cfg_idx_t;

  // Sequencer states, one-hot.
  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_M1    = 12'b0000_0000_0010,
    S_M2    = 12'b0000_0000_0100,
    S_M3    = 12'b0000_0000_1000,
    S_M4    = 12'b0000_0001_0000,
    S_M5    = 12'b0000_0010_0000,
    S_M6    = 12'b0000_0100_0000,
    S_M7    = 12'b0000_1000_0000,
    S_M8    = 12'b0001_0000_0000,
    S_RUN   = 12'b0010_0000_0000,
    S_DRAIN = 12'b0100_0000_0000,
    S_SAT   = 12'b1000_0000_0000
  } state_t;

endpackage

// ===== src/conv2d_padded_strided.sv =====
// Top level of the direct 2D convolution block with zero padding and stride.
// Depends on c2d_pkg, c2d_ram and conv2d_padded_strided_defines.svh.
//
//  Channel | Direction | Handshake            | Payload
//  in_     | slave     | in_tvalid/in_tready  | tdata: address, value, out_channel,
//          |           |                      | out_row, out_col; tuser: operation
//  out_    | master    | out_tvalid/out_tready| tdata: sum_value; tuser: saturated
//  cfg_    | write     | cfg_we               | cfg_index, cfg_wdata
//
// Load items are written to their store as they are accepted. A compute item
// runs eight setup steps, seven of them products on the shared multiplier, one
// multiply-accumulate per tap through the same multiplier, then pipeline drain
// and saturation. Reset (synchronous, rst_n low) clears control state only; the
// stores are undefined until written. in_tready is high only while no compute
// item is in progress. A finished result waits in the output register, and a
// stalled output holds the sequencer in its last step until taken.
`include "conv2d_padded_strided_defines.svh"

module conv2d_padded_strided import c2d_pkg::*; #(
  parameter int ACT_DEPTH        = ACT_DEPTH_DEF,
  parameter int WEIGHT_DEPTH     = WEIGHT_DEPTH_DEF,
  parameter int MAX_OUT_CHANNELS = MAX_OUT_CHANNELS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input items.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,  // address[13:0], value[45:14], out_channel[51:46],
                                 // out_row[58:52], out_col[65:59], zeros[71:66]
  input  logic [1:0]  in_tuser,  // operation[1:0]
  // Result items.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata, // sum_value[31:0]
  output logic [0:0]  out_tuser, // saturated[0]
  // Configuration writes.
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_wdata
);

  localparam int AAW = (ACT_DEPTH > 1) ? $clog2(ACT_DEPTH) : 1;
  localparam int WAW = (WEIGHT_DEPTH > 1) ? $clog2(WEIGHT_DEPTH) : 1;
  localparam int BAW = (MAX_OUT_CHANNELS > 1) ? $clog2(MAX_OUT_CHANNELS) : 1;

  // Input field unpacking.
  logic [13:0] in_address;
  logic [31:0] in_value;
  logic [5:0]  in_oc;
  logic [6:0]  in_row;
  logic [6:0]  in_col;
  op_t         in_op;
  idx_t        in_addr_ext;
  logic        in_accept;

  assign in_address  = in_tdata[13:0];
  assign in_value    = in_tdata[45:14];
  assign in_oc       = in_tdata[51:46];
  assign in_row      = in_tdata[58:52];
  assign in_col      = in_tdata[65:59];
  assign in_op       = op_t'(in_tuser);
  assign in_addr_ext = IDX_W'(in_address);
  assign in_accept   = in_tvalid && in_tready;

  // Configuration registers.
  logic [6:0] channels_in_r;
  logic [7:0] height_in_r;
  logic [7:0] width_in_r;
  logic [6:0] channels_out_r;
  logic [3:0] kernel_height_r;
  logic [3:0] kernel_width_r;
  logic [3:0] stride_r;
  logic [2:0] padding_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      channels_in_r   <= 7'd1;
      height_in_r     <= 8'd1;
      width_in_r      <= 8'd1;
      channels_out_r  <= 7'd1;
      kernel_height_r <= 4'd1;
      kernel_width_r  <= 4'd1;
      stride_r        <= 4'd1;
      padding_r       <= 3'd0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_CHANNELS_IN:   channels_in_r   <= cfg_wdata[6:0];
        CFG_HEIGHT_IN:     height_in_r     <= cfg_wdata;
        CFG_WIDTH_IN:      width_in_r      <= cfg_wdata;
        CFG_CHANNELS_OUT:  channels_out_r  <= cfg_wdata[6:0];
        CFG_KERNEL_HEIGHT: kernel_height_r <= cfg_wdata[3:0];
        CFG_KERNEL_WIDTH:  kernel_width_r  <= cfg_wdata[3:0];
        CFG_STRIDE:        stride_r        <= cfg_wdata[3:0];
        CFG_PADDING:       padding_r       <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  // Sequencer and datapath registers.
  state_t state_r, state_nxt;

  logic [5:0]  oc_r;
  logic [6:0]  orow_r;
  logic [6:0]  ocol_r;
  logic signed [PROD_W-1:0] p_r;
  logic [14:0] taps_r;
  logic [14:0] cnt_r;
  idx_t        widx_r;
  logic signed [12:0] r0_r;
  logic signed [12:0] c0_r;
  logic signed [12:0] r_r;
  logic signed [12:0] c_r;
  logic [16:0] hw_r;
  logic signed [25:0] row_off_r;
  logic signed [25:0] row_base_r;
  idx_t        chan_base_r;
  logic [3:0]  kh_r;
  logic [3:0]  kw_r;
  logic        v1_r;
  logic        v2_r;
  logic        act_ok1_r;
  logic        wgt_ok1_r;
  logic signed [ACC_W-1:0] acc_r;
  logic        out_tvalid_r;
  logic [31:0] out_data_r;
  logic        out_sat_r;

  // Stores.
  logic [ACT_W-1:0]  act_rd;
  logic [WGT_W-1:0]  wgt_rd;
  logic [BIAS_W-1:0] bias_rd;
  logic              act_we;
  logic              wgt_we;
  logic              bias_we;
  logic signed [25:0] aidx;

  assign act_we  = in_accept && (in_op == OP_LOAD_ACT) && (in_addr_ext < IDX_W'(ACT_DEPTH));
  assign wgt_we  = in_accept && (in_op == OP_LOAD_WGT)
                   && (in_addr_ext < IDX_W'(WEIGHT_DEPTH));
  assign bias_we = in_accept && (in_op == OP_LOAD_BIAS)
                   && (in_addr_ext < IDX_W'(MAX_OUT_CHANNELS));

  c2d_ram #(.WIDTH(ACT_W), .DEPTH(ACT_DEPTH), .ADDR_W(AAW)) u_act_ram (
    .clk   (clk),
    .we    (act_we),
    .waddr (in_addr_ext[AAW-1:0]),
    .wdata (in_value[ACT_W-1:0]),
    .raddr (aidx[AAW-1:0]),
    .rdata (act_rd)
  );

  c2d_ram #(.WIDTH(WGT_W), .DEPTH(WEIGHT_DEPTH), .ADDR_W(WAW)) u_wgt_ram (
    .clk   (clk),
    .we    (wgt_we),
    .waddr (in_addr_ext[WAW-1:0]),
    .wdata (in_value[WGT_W-1:0]),
    .raddr (widx_r[WAW-1:0]),
    .rdata (wgt_rd)
  );

  idx_t oc_ext;
  assign oc_ext = IDX_W'(oc_r);

  c2d_ram #(.WIDTH(BIAS_W), .DEPTH(MAX_OUT_CHANNELS), .ADDR_W(BAW)) u_bias_ram (
    .clk   (clk),
    .we    (bias_we),
    .waddr (in_addr_ext[BAW-1:0]),
    .wdata (in_value),
    .raddr (oc_ext[BAW-1:0]),
    .rdata (bias_rd)
  );

  // Tap address checks for the tap issued this cycle.
  logic r_ok;
  logic c_ok;
  logic act_ok;
  logic wgt_ok;
  logic bias_ok;

  assign aidx    = row_base_r + 26'(c_r);
  assign r_ok    = !r_r[12] && (r_r[11:0] < 12'(height_in_r));
  assign c_ok    = !c_r[12] && (c_r[11:0] < 12'(width_in_r));
  assign act_ok  = r_ok && c_ok && (aidx < 26'(ACT_DEPTH));
  assign wgt_ok  = widx_r < IDX_W'(WEIGHT_DEPTH);
  assign bias_ok = oc_ext < IDX_W'(MAX_OUT_CHANNELS);

  // Shared multiplier operand selection: setup products, else tap data.
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;

  always_comb begin
    mul_a = act_ok1_r ? MUL_A_W'($signed(act_rd)) : '0;
    mul_b = wgt_ok1_r ? MUL_B_W'($signed(wgt_rd)) : '0;
    case (state_r)
      S_M1: begin
        mul_a = MUL_A_W'(kernel_height_r);
        mul_b = MUL_B_W'(kernel_width_r);
      end
      S_M2: begin
        mul_a = p_r[MUL_A_W-1:0];
        mul_b = MUL_B_W'(channels_in_r);
      end
      S_M3: begin
        mul_a = p_r[MUL_A_W-1:0];
        mul_b = MUL_B_W'(oc_r);
      end
      S_M4: begin
        mul_a = MUL_A_W'(orow_r);
        mul_b = MUL_B_W'(stride_r);
      end
      S_M5: begin
        mul_a = MUL_A_W'(ocol_r);
        mul_b = MUL_B_W'(stride_r);
      end
      S_M6: begin
        mul_a = MUL_A_W'(height_in_r);
        mul_b = MUL_B_W'(width_in_r);
      end
      S_M7: begin
        mul_a = MUL_A_W'(r0_r);
        mul_b = MUL_B_W'(width_in_r);
      end
      default: ;
    endcase
  end

  // Loop control for the tap walk.
  logic kw_wrap;
  logic kh_wrap;
  logic last_tap;
  idx_t chan_next;
  logic signed [12:0] pad_s;

  assign kw_wrap   = (kw_r + 4'd1) == kernel_width_r;
  assign kh_wrap   = (kh_r + 4'd1) == kernel_height_r;
  assign last_tap  = cnt_r == 15'd1;
  assign chan_next = chan_base_r + IDX_W'(hw_r);
  assign pad_s     = $signed(13'(padding_r));

  // Output saturation.
  logic sat_hi;
  logic sat_lo;
  logic out_free;

  assign sat_hi   = acc_r > SUM_MAX;
  assign sat_lo   = acc_r < SUM_MIN;
  assign out_free = !out_tvalid_r || out_tready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_accept && (in_op == OP_COMPUTE)) state_nxt = S_M1;
      S_M1:    state_nxt = S_M2;
      S_M2:    state_nxt = S_M3;
      S_M3:    state_nxt = S_M4;
      S_M4:    state_nxt = S_M5;
      S_M5:    state_nxt = S_M6;
      S_M6:    state_nxt = S_M7;
      S_M7:    state_nxt = S_M8;
      S_M8:    state_nxt = (taps_r == 15'd0) ? S_DRAIN : S_RUN;
      S_RUN:   if (last_tap) state_nxt = S_DRAIN;
      S_DRAIN: if (!v1_r && !v2_r) state_nxt = S_SAT;
      S_SAT:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      v1_r    <= (state_r == S_RUN);
      v2_r    <= v1_r;
    end
  end

  // Datapath: setup captures, tap walk and accumulation.
  always_ff @(posedge clk) begin
    p_r       <= mul_a * mul_b;
    act_ok1_r <= act_ok;
    wgt_ok1_r <= wgt_ok;
    if (in_accept) begin
      oc_r   <= in_oc;
      orow_r <= in_row;
      ocol_r <= in_col;
    end
    if (v2_r) begin
      acc_r <= acc_r + ACC_W'(p_r);
    end
    case (state_r)
      S_M2: acc_r <= bias_ok ? ACC_W'($signed(bias_rd)) : '0;
      S_M3: taps_r <= p_r[14:0];
      S_M4: widx_r <= p_r[IDX_W-1:0];
      S_M5: r0_r <= $signed(p_r[12:0]) - pad_s;
      S_M6: c0_r <= $signed(p_r[12:0]) - pad_s;
      S_M7: hw_r <= p_r[16:0];
      S_M8: begin
        row_off_r   <= p_r[25:0];
        row_base_r  <= p_r[25:0];
        chan_base_r <= '0;
        r_r         <= r0_r;
        c_r         <= c0_r;
        kh_r        <= '0;
        kw_r        <= '0;
        cnt_r       <= taps_r;
      end
      S_RUN: begin
        cnt_r  <= cnt_r - 15'd1;
        widx_r <= widx_r + IDX_W'(1);
        if (kw_wrap) begin
          kw_r <= '0;
          c_r  <= c0_r;
          if (kh_wrap) begin
            // Next input channel.
            kh_r        <= '0;
            r_r         <= r0_r;
            chan_base_r <= chan_next;
            row_base_r  <= $signed(26'(chan_next)) + row_off_r;
          end else begin
            kh_r       <= kh_r + 4'd1;
            r_r        <= r_r + 13'sd1;
            row_base_r <= row_base_r + $signed(26'(width_in_r));
          end
        end else begin
          kw_r <= kw_r + 4'd1;
          c_r  <= c_r + 13'sd1;
        end
      end
      default: ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if ((state_r == S_SAT) && out_free) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_SAT) && out_free) begin
      out_sat_r <= sat_hi || sat_lo;
      if (sat_hi) begin
        out_data_r <= SUM_MAX[31:0];
      end else if (sat_lo) begin
        out_data_r <= SUM_MIN[31:0];
      end else begin
        out_data_r <= acc_r[31:0];
      end
    end
  end

  assign in_tready    = (state_r == S_IDLE);
  assign out_tvalid   = out_tvalid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_sat_r;

  // Checks.
  `C2D_ASSERT_NOW(a_idle_no_taps, clk, rst_n, in_tready, !v1_r && !v2_r)
  `C2D_ASSERT_NEXT(a_last_tap_drains, clk, rst_n, (state_r == S_RUN) && last_tap,
    state_r == S_DRAIN)
  `C2D_ASSERT_NEXT(a_tap_pipeline, clk, rst_n, v1_r, v2_r)
  `C2D_ASSERT_NOW(a_sat_value, clk, rst_n, out_tvalid && out_tuser[0],
    (out_tdata == 32'h7FFF_FFFF) || (out_tdata == 32'h8000_0000))

endmodule

// ===== src/c2d_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on c2d_pkg for its parameter defaults.
module c2d_ram import c2d_pkg::*; #(
  parameter int WIDTH  = ACT_W,
  parameter int DEPTH  = ACT_DEPTH_DEF,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_r;

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rd_r <= mem_r[raddr];
  end

  assign rdata = rd_r;

endmodule
